/* rtl/core/sem_pkg.sv */
// Package for the Sobel edge magnitude core: shared widths, register indexes,
// controller state type and the command/status structs between controller and datapath.
// No dependencies.
`default_nettype none
package sem_pkg;

  localparam int unsigned PixW   = 8;
  localparam int unsigned WidthW = 11;
  localparam int unsigned HeightW = 13;
  localparam int unsigned ThrW   = 8;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgDataW = 13;
  localparam int unsigned GradW  = 12;
  localparam int unsigned SqW    = 22;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] CfgFrameWidth  = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgFrameHeight = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgEdgeThresh  = 2'd2;

  typedef enum logic [2:0] {
    StClear,
    StIdle,
    StRead,
    StGrad,
    StSq1,
    StSq2,
    StSqrt,
    StOut
  } sem_state_e;

  typedef struct packed {
    logic clear_step;
    logic accept;
    logic grad;
    logic sq1;
    logic sq2;
    logic sqrt_step;
    logic out_load;
  } sem_cmd_t;

  typedef struct packed {
    logic clear_done;
    logic has_result;
    logic below_thr;
    logic sqrt_done;
    logic out_free;
  } sem_sts_t;

endpackage
`default_nettype wire

/* rtl/core/sem_ctrl.sv */
// Controller state machine of the Sobel edge magnitude core.
// Depends on sem_pkg for the state type and the command/status structs.
`default_nettype none
module sem_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  input  wire sem_pkg::sem_sts_t sts_i,
  output sem_pkg::sem_cmd_t      cmd_o,
  output logic                   in_ready_o
);

  sem_pkg::sem_state_e state_q, state_d;

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      sem_pkg::StClear: if (sts_i.clear_done) state_d = sem_pkg::StIdle;
      sem_pkg::StIdle:  if (in_valid_i) state_d = sem_pkg::StRead;
      sem_pkg::StRead:  state_d = sem_pkg::StGrad;
      sem_pkg::StGrad:  state_d = sts_i.has_result ? sem_pkg::StSq1 : sem_pkg::StIdle;
      sem_pkg::StSq1:   state_d = sem_pkg::StSq2;
      sem_pkg::StSq2:   state_d = sem_pkg::StSqrt;
      sem_pkg::StSqrt:  if (sts_i.below_thr || sts_i.sqrt_done) state_d = sem_pkg::StOut;
      sem_pkg::StOut:   if (sts_i.out_free) state_d = sem_pkg::StIdle;
      default:          state_d = sem_pkg::StIdle;
    endcase
  end

  // Commands to the datapath.
  always_comb begin
    cmd_o = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      sem_pkg::StClear: cmd_o.clear_step = 1'b1;
      sem_pkg::StIdle: begin
        in_ready_o   = 1'b1;
        cmd_o.accept = in_valid_i;
      end
      sem_pkg::StRead: ;
      sem_pkg::StGrad: cmd_o.grad = 1'b1;
      sem_pkg::StSq1:  cmd_o.sq1 = 1'b1;
      sem_pkg::StSq2:  cmd_o.sq2 = 1'b1;
      sem_pkg::StSqrt: cmd_o.sqrt_step = !(sts_i.below_thr || sts_i.sqrt_done);
      sem_pkg::StOut:  cmd_o.out_load = sts_i.out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= sem_pkg::StClear;
    end else begin
      state_q <= state_d;
    end
  end

endmodule
`default_nettype wire

/* rtl/core/sem_datapath.sv */
// Datapath of the Sobel edge magnitude core: configuration registers, position
// counters, line stores, 3x3 window, gradients, squares and an iterative square root.
// Depends on sem_pkg.
`default_nettype none
module sem_datapath #(
  parameter int unsigned MAX_WIDTH  = 1024,
  parameter int unsigned MAX_HEIGHT = 4096
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire sem_pkg::sem_cmd_t              cmd_i,
  output sem_pkg::sem_sts_t                   sts_o,
  input  wire logic                           cfg_valid_i,
  input  wire logic [sem_pkg::CfgIdxW-1:0]    cfg_index_i,
  input  wire logic [sem_pkg::CfgDataW-1:0]   cfg_data_i,
  input  wire logic [sem_pkg::PixW-1:0]       pixel_i,
  output logic                                out_valid_o,
  input  wire logic                           out_ready_i,
  output logic [sem_pkg::PixW-1:0]            edge_value_o,
  output logic                                frame_last_o
);

  localparam int unsigned ColW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int unsigned RowW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
  localparam logic [ColW-1:0] LastAddr = ColW'(MAX_WIDTH - 1);
  localparam int unsigned PW = sem_pkg::PixW;
  localparam int unsigned GW = sem_pkg::GradW;
  localparam int unsigned SW = sem_pkg::SqW;

  // Configuration registers.
  logic [sem_pkg::WidthW-1:0]  frame_width_q;
  logic [sem_pkg::HeightW-1:0] frame_height_q;
  logic [sem_pkg::ThrW-1:0]    edge_threshold_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_width_q    <= sem_pkg::WidthW'(640);
      frame_height_q   <= sem_pkg::HeightW'(480);
      edge_threshold_q <= sem_pkg::ThrW'(10);
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        sem_pkg::CfgFrameWidth:  frame_width_q <= cfg_data_i[sem_pkg::WidthW-1:0];
        sem_pkg::CfgFrameHeight: frame_height_q <= cfg_data_i;
        sem_pkg::CfgEdgeThresh:  edge_threshold_q <= cfg_data_i[sem_pkg::ThrW-1:0];
        default: ;
      endcase
    end
  end

  // Effective frame size, clamped to the supported range.
  logic [31:0] w_eff, h_eff;
  always_comb begin
    w_eff = 32'(frame_width_q);
    if (w_eff < 32'd3) w_eff = 32'd3;
    else if (w_eff > 32'(MAX_WIDTH)) w_eff = 32'(MAX_WIDTH);
    h_eff = 32'(frame_height_q);
    if (h_eff < 32'd3) h_eff = 32'd3;
    else if (h_eff > 32'(MAX_HEIGHT)) h_eff = 32'(MAX_HEIGHT);
  end

  // Position counters and per-transaction flags, updated when a pixel is accepted.
  logic [ColW-1:0] col_q, idx_q;
  logic [RowW-1:0] row_q;
  logic            has_result_q, last_q;
  logic            row_end, frame_end;

  assign row_end   = 32'(col_q) >= (w_eff - 32'd1);
  assign frame_end = row_end && (32'(row_q) >= (h_eff - 32'd1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q        <= '0;
      row_q        <= '0;
      has_result_q <= 1'b0;
      last_q       <= 1'b0;
    end else if (cmd_i.accept) begin
      has_result_q <= (32'(col_q) >= 32'd2) && (32'(row_q) >= 32'd2);
      last_q       <= frame_end;
      if (row_end) begin
        col_q <= '0;
        row_q <= frame_end ? '0 : row_q + RowW'(1);
      end else begin
        col_q <= col_q + ColW'(1);
      end
    end
  end

  // Pixel and address of the transaction in flight.
  logic [PW-1:0] pix_q;
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      pix_q <= pixel_i;
      idx_q <= col_q;
    end
  end

  // Line stores: read at accept, written back in the gradient cycle, zeroed by the clearing pass.
  logic [PW-1:0] mem_upper [MAX_WIDTH];
  logic [PW-1:0] mem_middle [MAX_WIDTH];
  logic [PW-1:0] top_q, mid_q;
  logic [ColW-1:0] clr_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.clear_step) begin
      mem_upper[clr_q] <= '0;
    end else if (cmd_i.grad) begin
      mem_upper[idx_q] <= mid_q;
    end
    if (cmd_i.accept) begin
      top_q <= mem_upper[col_q];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.clear_step) begin
      mem_middle[clr_q] <= '0;
    end else if (cmd_i.grad) begin
      mem_middle[idx_q] <= pix_q;
    end
    if (cmd_i.accept) begin
      mid_q <= mem_middle[col_q];
    end
  end

  // Clearing pass address.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q <= '0;
    end else if (cmd_i.clear_step && clr_q != LastAddr) begin
      clr_q <= clr_q + ColW'(1);
    end
  end

  // Window: entries 0..2 hold column c-2, rows top to bottom; 3..5 hold column c-1.
  logic [PW-1:0] win_q [6];
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 6; i++) win_q[i] <= '0;
    end else if (cmd_i.grad) begin
      win_q[0] <= win_q[3];
      win_q[1] <= win_q[4];
      win_q[2] <= win_q[5];
      win_q[3] <= top_q;
      win_q[4] <= mid_q;
      win_q[5] <= pix_q;
    end
  end

  // Sobel gradients.
  logic signed [GW-1:0] gx_d, gy_d, gx_q, gy_q;
  always_comb begin
    gx_d = (GW'(top_q) + (GW'(mid_q) <<< 1) + GW'(pix_q))
         - (GW'(win_q[0]) + (GW'(win_q[1]) <<< 1) + GW'(win_q[2]));
    gy_d = (GW'(win_q[0]) + (GW'(win_q[3]) <<< 1) + GW'(top_q))
         - (GW'(win_q[2]) + (GW'(win_q[5]) <<< 1) + GW'(pix_q));
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.grad) begin
      gx_q <= gx_d;
      gy_q <= gy_d;
    end
  end

  // Squares of the two gradients, one in each of the sq1 and sq2 states, and the threshold compare.
  logic [SW-1:0] sqx_q, n_d, thr2;
  logic signed [2*GW-1:0] sqx_full, sqy_full;
  assign sqx_full = gx_q * gx_q;
  assign sqy_full = gy_q * gy_q;
  assign n_d      = sqx_q + sqy_full[SW-1:0];
  assign thr2     = SW'(edge_threshold_q) * SW'(edge_threshold_q);

  // Square root state: one result bit per iteration.
  logic [SW-1:0] rem_q, root_q, bit_q;
  logic          below_q;
  logic [SW:0]   trial;
  assign trial = {1'b0, root_q} + {1'b0, bit_q};

  always_ff @(posedge clk_i) begin
    if (cmd_i.sq1) begin
      sqx_q <= sqx_full[SW-1:0];
    end
    if (cmd_i.sq2) begin
      rem_q   <= n_d;
      below_q <= n_d <= thr2;
      root_q  <= '0;
      bit_q   <= SW'(1) << 20;
    end else if (cmd_i.sqrt_step) begin
      if ({1'b0, rem_q} >= trial) begin
        rem_q  <= rem_q - trial[SW-1:0];
        root_q <= (root_q >> 1) + bit_q;
      end else begin
        root_q <= root_q >> 1;
      end
      bit_q <= bit_q >> 2;
    end
  end

  // Output register.
  logic [PW-1:0] result;
  always_comb begin
    if (below_q) result = '0;
    else if (root_q > SW'(255)) result = PW'(255);
    else result = root_q[PW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_o <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_o <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      edge_value_o <= result;
      frame_last_o <= last_q;
    end
  end

  // Status to the controller.
  always_comb begin
    sts_o.clear_done = clr_q == LastAddr;
    sts_o.has_result = has_result_q;
    sts_o.below_thr  = below_q;
    sts_o.sqrt_done  = bit_q == '0;
    sts_o.out_free   = !out_valid_o || out_ready_i;
  end

endmodule
`default_nettype wire

/* rtl/core/sobel_edge_magnitude_core.sv */
// Sobel 3x3 edge magnitude core. Pixels enter in raster order on the input
// channel; for each interior pixel one 8-bit magnitude leaves on the output
// channel, with frame_last_o set on the last result of a frame.
// Configuration writes (frame width, frame height, threshold) go in through the
// cfg channel, which is always ready; the user must make them only while the
// core is idle, which the core itself does not enforce. One pixel is processed
// at a time: a border pixel passes the read and gradient states; an interior
// pixel below threshold then passes the square, square root and output states;
// one above threshold also runs the 11 iterations of the one-bit-per-cycle
// square root unit. The output register loads as the controller leaves StOut.
// After reset the two line stores are zeroed, one entry per cycle, across all
// MAX_WIDTH entries; in_ready_o stays low during that pass.
// The output register lets the next pixel be accepted while a result waits;
// if the receiver stalls, the following result waits in the core until the
// register frees and no further pixel is taken.
// Depends on sem_pkg, sem_ctrl and sem_datapath.
`default_nettype none
module sobel_edge_magnitude_core #(
  parameter int unsigned MAX_WIDTH  = 1024,
  parameter int unsigned MAX_HEIGHT = 4096
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           cfg_valid_i,
  output logic                                cfg_ready_o,
  input  wire logic [sem_pkg::CfgIdxW-1:0]    cfg_index_i,
  input  wire logic [sem_pkg::CfgDataW-1:0]   cfg_data_i,
  input  wire logic                           in_valid_i,
  output logic                                in_ready_o,
  input  wire logic [sem_pkg::PixW-1:0]       pixel_i,
  output logic                                out_valid_o,
  input  wire logic                           out_ready_i,
  output logic [sem_pkg::PixW-1:0]            edge_value_o,
  output logic                                frame_last_o
);

  sem_pkg::sem_cmd_t cmd;
  sem_pkg::sem_sts_t sts;

  assign cfg_ready_o = 1'b1;

  sem_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .sts_i      (sts),
    .cmd_o      (cmd),
    .in_ready_o (in_ready_o)
  );

  sem_datapath #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .pixel_i      (pixel_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .edge_value_o (edge_value_o),
    .frame_last_o (frame_last_o)
  );

endmodule
`default_nettype wire

/* rtl/core/sem_checker.sv */
// Port-level checker for the Sobel edge magnitude core, bound to the top level.
// Depends on sem_pkg for the port widths.
`default_nettype none
module sem_checker (
  input wire logic                     clk_i,
  input wire logic                     rst_ni,
  input wire logic                     in_valid_i,
  input wire logic                     in_ready_o,
  input wire logic                     out_valid_o,
  input wire logic                     out_ready_i,
  input wire logic [sem_pkg::PixW-1:0] edge_value_o,
  input wire logic                     frame_last_o
);

  // A stalled result keeps its payload.
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(edge_value_o)
      && $stable(frame_last_o))
    else $error("result changed while stalled");

  // A result is withdrawn only after its transaction.
  a_out_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(out_valid_o) |-> $past(out_ready_i))
    else $error("result dropped without transaction");

  // After an input transaction the core is busy with that pixel and holds in_ready_o low.
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o ##1 !in_ready_o)
    else $error("input accepted while a pixel is in flight");

  // The core never takes a pixel in the cycle right after reset.
  a_reset_busy: assert property (@(posedge clk_i)
    !rst_ni |=> !in_ready_o)
    else $error("ready during clearing pass");

endmodule

bind sobel_edge_magnitude_core sem_checker u_sem_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_valid_i),
  .in_ready_o   (in_ready_o),
  .out_valid_o  (out_valid_o),
  .out_ready_i  (out_ready_i),
  .edge_value_o (edge_value_o),
  .frame_last_o (frame_last_o)
);
`default_nettype wire
